// ----- rtl/core/slsfp_pkg.sv -----
package slsfp_pkg;

  // fixed field widths
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // output tdata: is_ack, message_id, payload_length, has_payload,
  // byte_position, payload_byte, frame_sum (37 bits) padded to 40
  localparam int unsigned OUT_FIELDS_W = 1 + DATA_W + LEN_W + 1 + POS_W + DATA_W + DATA_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 32;

  // configuration register reset values
  localparam logic [DATA_W-1:0] FIRST_SYNC_RST  = 8'h55;
  localparam logic [DATA_W-1:0] SYNC_UPLOAD_RST = 8'hAA;
  localparam logic [DATA_W-1:0] SYNC_ACK_RST    = 8'hAF;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 6'd28;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SYNC  = 2'd0,
    CFG_SYNC_UPLOAD = 2'd1,
    CFG_SYNC_ACK    = 2'd2,
    CFG_MAX_PAYLOAD = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_SYNC1 = 3'd0,
    ST_SYNC2 = 3'd1,
    ST_ID    = 3'd2,
    ST_LEN   = 3'd3,
    ST_DATA  = 3'd4,
    ST_SUM   = 3'd5,
    ST_READ  = 3'd6,
    ST_LOAD  = 3'd7
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic sum_load;
    logic sum_add;
    logic set_ack;
    logic load_id;
    logic load_len;
    logic store_byte;
    logic clr_idx;
    logic rd_issue;
    logic out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match_first;
    logic match_second;
    logic len_ok;
    logic len_in_zero;
    logic fill_done;
    logic sum_match;
    logic held_zero;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/slsfp_ctrl.sv -----
module slsfp_ctrl
  import slsfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
    end else begin
      state_q <= state_d;
    end
  end

  assign rx_ready_o = (state_q != ST_READ) && (state_q != ST_LOAD);
  assign accept     = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_SYNC1: begin
        if (accept) begin
          cmd_o.sum_load = 1'b1;
          if (status_i.match_first) state_d = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (accept) begin
          cmd_o.sum_add = 1'b1;
          if (status_i.match_second) begin
            cmd_o.set_ack = 1'b1;
            state_d       = ST_ID;
          end else begin
            state_d = ST_SYNC1;
          end
        end
      end
      ST_ID: begin
        if (accept) begin
          cmd_o.load_id = 1'b1;
          cmd_o.sum_add = 1'b1;
          state_d       = ST_LEN;
        end
      end
      ST_LEN: begin
        if (accept) begin
          if (status_i.len_ok) begin
            cmd_o.load_len = 1'b1;
            cmd_o.sum_add  = 1'b1;
            state_d        = status_i.len_in_zero ? ST_SUM : ST_DATA;
          end else begin
            state_d = ST_SYNC1;
          end
        end
      end
      ST_DATA: begin
        if (accept) begin
          cmd_o.store_byte = 1'b1;
          cmd_o.sum_add    = 1'b1;
          if (status_i.fill_done) state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (accept) begin
          if (status_i.sum_match) begin
            cmd_o.clr_idx = 1'b1;
            state_d       = status_i.held_zero ? ST_LOAD : ST_READ;
          end else begin
            state_d = ST_SYNC1;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = status_i.emit_last ? ST_SYNC1 : ST_READ;
        end
      end
      default: begin
        state_d = ST_SYNC1;
      end
    endcase
  end

  // a result is loaded only after its byte was fetched (possibly waiting on
  // the output register since), or for an empty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load && !status_i.held_zero
    |-> $past(state_q) == ST_READ || $past(state_q) == ST_LOAD)
    else $error("result loaded without a store read");

  // a good checksum always leads into the emit sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && state_q == ST_SUM && status_i.sum_match
    |=> state_q == ST_READ || state_q == ST_LOAD)
    else $error("good frame not emitted");

endmodule

// ----- rtl/core/slsfp_dp.sv -----
module slsfp_dp
  import slsfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [DATA_W-1:0]      rx_byte_i,
  input  ctl_cmd_t               cmd_i,
  output dp_status_t             status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_last_o
);

  localparam int unsigned IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [DATA_W-1:0] DEPTH_C = DATA_W'(PAYLOAD_DEPTH);

  // configuration registers
  logic [DATA_W-1:0] first_sync_q, sync_upload_q, sync_ack_q;
  logic [LEN_W-1:0]  max_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q  <= FIRST_SYNC_RST;
      sync_upload_q <= SYNC_UPLOAD_RST;
      sync_ack_q    <= SYNC_ACK_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_SYNC:  first_sync_q  <= cfg_data_i;
        CFG_SYNC_UPLOAD: sync_upload_q <= cfg_data_i;
        CFG_SYNC_ACK:    sync_ack_q    <= cfg_data_i;
        CFG_MAX_PAYLOAD: max_payload_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame registers
  logic [DATA_W-1:0] sum_q, id_q, rd_q;
  logic [LEN_W-1:0]  len_q, fill_q, idx_q;
  logic              ack_q;
  logic [DATA_W-1:0] store_q [PAYLOAD_DEPTH];
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  assign wr_addr = IDX_W'(fill_q);
  assign rd_addr = IDX_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_load) sum_q <= rx_byte_i;
    else if (cmd_i.sum_add) sum_q <= sum_q + rx_byte_i;
    if (cmd_i.set_ack) ack_q <= (rx_byte_i != sync_upload_q);
    if (cmd_i.load_id) id_q <= rx_byte_i;
    if (cmd_i.load_len) len_q <= rx_byte_i[LEN_W-1:0];
    if (cmd_i.store_byte) store_q[wr_addr] <= rx_byte_i;
    if (cmd_i.rd_issue) rd_q <= store_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.load_len) fill_q <= '0;
      else if (cmd_i.store_byte) fill_q <= fill_q + 1'b1;
      if (cmd_i.clr_idx) idx_q <= '0;
      else if (cmd_i.out_load) idx_q <= idx_q + 1'b1;
    end
  end

  // status
  logic [LEN_W:0] fill_nx, idx_nx;
  assign fill_nx = {1'b0, fill_q} + 1'b1;
  assign idx_nx  = {1'b0, idx_q} + 1'b1;

  assign status_o.match_first  = (rx_byte_i == first_sync_q);
  assign status_o.match_second = (rx_byte_i == sync_upload_q) || (rx_byte_i == sync_ack_q);
  assign status_o.len_ok       = (rx_byte_i <= {2'b00, max_payload_q}) && (rx_byte_i <= DEPTH_C);
  assign status_o.len_in_zero  = (rx_byte_i == '0);
  assign status_o.fill_done    = (fill_nx >= {1'b0, len_q});
  assign status_o.sum_match    = (rx_byte_i == sum_q);
  assign status_o.held_zero    = (len_q == '0);
  assign status_o.emit_last    = (len_q == '0) || (idx_nx == {1'b0, len_q});
  assign status_o.out_free     = !out_valid_o || out_ready_i;

  // output register
  logic                   valid_q;
  logic [OUT_TDATA_W-1:0] data_q;
  logic                   last_q;
  logic                   has_pl;
  logic [DATA_W-1:0]      pl_byte;

  assign has_pl  = (len_q != '0);
  assign pl_byte = has_pl ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      data_q <= OUT_TDATA_W'({sum_q, pl_byte, idx_q[POS_W-1:0], has_pl, len_q, id_q, ack_q});
      last_q <= status_o.emit_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

  // payload bytes are written only inside the announced length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_byte |-> fill_q < len_q)
    else $error("payload write beyond frame length");

  // store reads only happen for a non-empty frame, inside its length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> (len_q != '0) && (idx_q < len_q))
    else $error("store read outside frame");

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !valid_q || out_ready_i)
    else $error("pending result overwritten");

endmodule

// ----- rtl/core/sync_length_sum_frame_parser_unit.sv -----
// channel    | dir | handshake                     | contents
// -----------+-----+-------------------------------+----------------------------------------
// s_axis     | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] rx_byte
// m_axis     | out | m_axis_tvalid / m_axis_tready | tdata: frame result fields, tlast: last
// cfg        | in  | cfg_we_i (no wait)            | cfg_idx_i register index, cfg_data_i
//
// one received byte is taken per cycle while the parser is collecting a frame
// a good checksum starts a burst: each result takes a store read, then an output
// register load, and the input is held off until the burst ends; an empty frame
// skips the store read and gives one result
// downstream stalls hold the burst at the output register; the input side
// reopens as soon as the last result of the frame is loaded
// reset puts the parser in sync hunting and restores the register defaults;
// the payload store is not cleared
module sync_length_sum_frame_parser_unit
  import slsfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // received bytes
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
  // frame results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] is_ack, [8:1] message_id, [14:9] payload_length, [15] has_payload,
  // [20:16] byte_position, [28:21] payload_byte, [36:29] frame_sum, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast    // last result of the frame
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer: frame phases plus the emit loop
  slsfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (s_axis_tvalid),
    .rx_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // config registers, running sum, header fields, payload store, output register
  slsfp_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- bench/tb_sync_length_sum_frame_parser_unit.sv -----
`timescale 1ns / 1ps

module tb_sync_length_sum_frame_parser_unit;
  import slsfp_pkg::*;

  localparam int unsigned STORE_DEPTH  = PAYLOAD_DEPTH_DEF;
  // drain wait covers the longest burst, a store read and an output load per stored byte, plus margin
  localparam int unsigned DRAIN_CYCLES = 2 * STORE_DEPTH + 10;
  localparam int unsigned MAX_REPORTS  = 10;

  // one frame result as the parser hands it out
  typedef struct packed {
    logic              is_ack;
    logic [DATA_W-1:0] msg_id;
    logic [LEN_W-1:0]  pay_len;
    logic              has_data;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] sum;
    logic              last;
  } frame_result_t;

  // shapes of byte sequences the stimulus builds
  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_SYNC2,
    FR_TOO_LONG
  } frame_kind_e;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = CFG_FIRST_SYNC;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  sync_length_sum_frame_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [0] is_ack, [8:1] message_id, [14:9] payload_length, [15] has_payload,
    // [20:16] byte_position, [28:21] payload_byte, [36:29] frame_sum
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)    // last result of the frame
  );

  // register copies, kept in step with every write
  logic [DATA_W-1:0] sync_first  = FIRST_SYNC_RST;
  logic [DATA_W-1:0] sync_upload = SYNC_UPLOAD_RST;
  logic [DATA_W-1:0] sync_ack    = SYNC_ACK_RST;
  logic [LEN_W-1:0]  len_limit   = MAX_PAYLOAD_RST;

  // parser state as the checker sees it
  state_e            parse_ph = ST_SYNC1;
  logic [DATA_W-1:0] sum_acc  = '0;
  int                fill_cnt = 0;
  logic [DATA_W-1:0] held_id  = '0;
  logic [LEN_W-1:0]  held_len = '0;
  logic              held_ack = 1'b0;
  logic [DATA_W-1:0] byte_store [STORE_DEPTH];

  logic [DATA_W-1:0] rx_bytes_q [$];       // bytes waiting to be offered
  frame_result_t     frame_results_q [$];  // results owed by frames already checked
  int                queued_bytes = 0;
  int                mismatch_cnt = 0;
  logic              rx_taken     = 1'b0;  // byte request accepted at the last edge
  logic              quiet_tail   = 1'b0;  // no idling on either side once set
  int                src_gap      = 0;
  int                sink_gap     = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // expected behavior: one received byte moves the parser one step, a good
  // checksum byte releases the whole frame as results
  // ---------------------------------------------------------------------------
  task automatic parse_rx_byte(input logic [DATA_W-1:0] b);
    int            cnt;
    frame_result_t r;
    case (parse_ph)
      ST_SYNC2: begin
        // a wrong second sync drops back to hunting without a retry
        if (b == sync_upload || b == sync_ack) begin
          held_ack = (b != sync_upload);  // equal registers count as upload
          parse_ph = ST_ID;
        end else begin
          parse_ph = ST_SYNC1;
        end
        sum_acc = sum_acc + b;
      end
      ST_ID: begin
        held_id  = b;
        sum_acc  = sum_acc + b;
        parse_ph = ST_LEN;
      end
      ST_LEN: begin
        if (b <= len_limit && b <= STORE_DEPTH) begin
          held_len = b[LEN_W-1:0];
          fill_cnt = 0;
          sum_acc  = sum_acc + b;
          parse_ph = (b != 0) ? ST_DATA : ST_SUM;
        end else begin
          parse_ph = ST_SYNC1;  // oversize frame is dropped
        end
      end
      ST_DATA: begin
        byte_store[fill_cnt] = b;
        fill_cnt++;
        sum_acc = sum_acc + b;
        if (fill_cnt >= held_len) parse_ph = ST_SUM;
      end
      ST_SUM: begin
        // bad checksum: nothing comes out
        if (sum_acc == b) begin
          cnt = (held_len != 0) ? int'(held_len) : 1;
          for (int k = 0; k < cnt; k++) begin
            r.is_ack   = held_ack;
            r.msg_id   = held_id;
            r.pay_len  = held_len;
            r.has_data = (held_len != 0);
            r.pos      = k[POS_W-1:0];
            r.data     = r.has_data ? byte_store[k] : '0;
            r.sum      = sum_acc;
            r.last     = (k == cnt - 1);
            frame_results_q.push_back(r);
          end
        end
        parse_ph = ST_SYNC1;
      end
      default: begin
        // hunting: the sum restarts on every byte seen
        parse_ph = (b == sync_first) ? ST_SYNC2 : ST_SYNC1;
        sum_acc  = b;
      end
    endcase
  endtask

  function automatic string fmt_result(input frame_result_t r);
    return $sformatf("ack=%0d id=%02h len=%0d has=%0d pos=%0d byte=%02h sum=%02h last=%0d",
                     r.is_ack, r.msg_id, r.pay_len, r.has_data, r.pos, r.data, r.sum,
                     r.last);
  endfunction

  task automatic log_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // byte source: inputs change on the falling edge, a pending request is held
  // until accepted, random idle bursts fall between requests
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !rx_taken) begin
      // request still pending, keep it as is
    end else if (src_gap > 0) begin
      src_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (rx_bytes_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (!quiet_tail && $urandom_range(5, 0) == 0) begin
      src_gap = $urandom_range(4, 0);
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= rx_bytes_q[0];
    end
    rx_taken = 1'b0;
  end

  // result sink: back-pressure in random bursts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(4, 0) == 0) begin
      sink_gap = $urandom_range(4, 0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled on the rising edge; results are checked
  // against the oldest expectation, accepted bytes feed the parser copy
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    frame_result_t got;
    frame_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.is_ack   = m_axis_tdata[0];
        got.msg_id   = m_axis_tdata[8:1];
        got.pay_len  = m_axis_tdata[14:9];
        got.has_data = m_axis_tdata[15];
        got.pos      = m_axis_tdata[20:16];
        got.data     = m_axis_tdata[28:21];
        got.sum      = m_axis_tdata[36:29];
        got.last     = m_axis_tlast;
        if (frame_results_q.size() == 0) begin
          log_error($sformatf("unexpected result: %s", fmt_result(got)));
        end else begin
          want = frame_results_q.pop_front();
          if (got !== want)
            log_error($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                fmt_result(want), fmt_result(got)));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata);
        void'(rx_bytes_q.pop_front());
        rx_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_rx(input logic [DATA_W-1:0] b);
    rx_bytes_q.push_back(b);
    queued_bytes++;
  endtask

  // builds one frame from the current register values; fill < 0 means random
  // payload, otherwise every payload byte is that value
  task automatic queue_frame(input frame_kind_e kind, input logic ack_sel,
                             input logic [DATA_W-1:0] id, input int len, input int fill);
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] s2;
    logic [DATA_W-1:0] pay;
    logic [DATA_W-1:0] flip;
    sum = sync_first;
    push_rx(sync_first);
    if (kind == FR_BAD_SYNC2) begin
      do s2 = DATA_W'($urandom); while (s2 == sync_upload || s2 == sync_ack);
      push_rx(s2);
      return;
    end
    s2 = ack_sel ? sync_ack : sync_upload;
    push_rx(s2);
    sum = sum + s2;
    push_rx(id);
    sum = sum + id;
    push_rx(len[DATA_W-1:0]);
    if (kind == FR_TOO_LONG) return;
    sum = sum + len[DATA_W-1:0];
    for (int i = 0; i < len; i++) begin
      pay = (fill < 0) ? DATA_W'($urandom) : fill[DATA_W-1:0];
      push_rx(pay);
      sum = sum + pay;
    end
    if (kind == FR_BAD_SUM) begin
      flip = DATA_W'($urandom_range(255, 1));
      sum  = sum ^ flip;
    end
    push_rx(sum);
  endtask

  // mostly short payloads, now and then anything up to the limit
  function automatic int pick_len();
    int cap;
    if (len_limit == 0) return 0;
    cap = (len_limit < 6) ? int'(len_limit) : 6;
    if ($urandom_range(4, 0) != 0) return $urandom_range(cap, 0);
    return $urandom_range(int'(len_limit), 0);
  endfunction

  // mostly good frames with random content, the rest broken frames and line noise
  task automatic run_random(input int budget);
    int                frame_bytes;
    int                mark;
    int                roll;
    logic [DATA_W-1:0] id;
    logic              ack_sel;
    frame_bytes = 0;
    while (frame_bytes < budget) begin
      roll    = $urandom_range(99, 0);
      id      = DATA_W'($urandom);
      ack_sel = 1'($urandom_range(1, 0));
      mark    = queued_bytes;
      if (roll < 70) begin
        queue_frame(FR_GOOD, ack_sel, id, pick_len(), -1);
      end else if (roll < 80) begin
        queue_frame(FR_BAD_SUM, ack_sel, id, pick_len(), -1);
      end else if (roll < 87) begin
        queue_frame(FR_BAD_SYNC2, ack_sel, id, 0, -1);
      end else if (roll < 93) begin
        queue_frame(FR_TOO_LONG, ack_sel, id, $urandom_range(255, int'(len_limit) + 1), -1);
      end else begin
        // noise is not counted as stimulus
        repeat ($urandom_range(4, 1)) push_rx(DATA_W'($urandom));
        mark = queued_bytes;
      end
      frame_bytes += queued_bytes - mark;
    end
  endtask

  // all expected results in, then room for a frame that ends without a result
  task automatic wait_drained();
    while (rx_bytes_q.size() != 0 || frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [DATA_W-1:0] first, input logic [DATA_W-1:0] up,
                              input logic [DATA_W-1:0] ack, input logic [LEN_W-1:0] lim);
    cfg_idx_e idx;
    logic [CFG_DATA_W-1:0] val;
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       begin idx = CFG_FIRST_SYNC;  val = first;              sync_first  = first; end
        1:       begin idx = CFG_SYNC_UPLOAD; val = up;                 sync_upload = up;    end
        2:       begin idx = CFG_SYNC_ACK;    val = ack;                sync_ack    = ack;   end
        default: begin idx = CFG_MAX_PAYLOAD; val = CFG_DATA_W'(lim);   len_limit   = lim;   end
      endcase
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] r_first;
    logic [DATA_W-1:0] r_up;
    logic [DATA_W-1:0] r_ack;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: hunting noise, empty frame, full-scale id and payload,
    // wrong second sync, length just over the limit, bad checksum
    push_rx(8'h00);
    push_rx(8'hFF);
    queue_frame(FR_GOOD, 1'b0, 8'h00, 0, -1);
    queue_frame(FR_GOOD, 1'b1, 8'hFF, 1, 8'hFF);
    queue_frame(FR_BAD_SYNC2, 1'b0, 8'h00, 0, -1);
    queue_frame(FR_TOO_LONG, 1'b0, 8'h3C, int'(len_limit) + 1, -1);
    queue_frame(FR_BAD_SUM, 1'b1, 8'h5A, 0, -1);
    run_random(20);
    wait_drained();

    // low/high sync extremes, deepest store
    write_config(8'h00, 8'hFF, 8'h80, LEN_W'(STORE_DEPTH));
    queue_frame(FR_GOOD, 1'b1, 8'h81, int'(STORE_DEPTH), -1);
    queue_frame(FR_TOO_LONG, 1'b0, 8'h7E, int'(STORE_DEPTH) + 1, -1);
    queue_frame(FR_GOOD, 1'b0, 8'h01, 2, 8'h00);
    run_random(15);
    wait_drained();

    // both second sync values equal, only empty frames allowed
    write_config(8'hFF, 8'h00, 8'h00, '0);
    queue_frame(FR_GOOD, 1'b1, 8'hA5, 0, -1);
    queue_frame(FR_TOO_LONG, 1'b0, 8'h5A, 1, -1);
    queue_frame(FR_TOO_LONG, 1'b1, 8'h00, 255, -1);
    run_random(15);
    wait_drained();

    // random registers with distinct second sync values
    r_first = DATA_W'($urandom);
    r_up    = DATA_W'($urandom);
    do r_ack = DATA_W'($urandom); while (r_ack == r_up);
    write_config(r_first, r_up, r_ack, LEN_W'($urandom_range(int'(STORE_DEPTH), 1)));
    run_random(35);
    wait_drained();

    // final stretch with both sides always ready
    r_first = DATA_W'($urandom);
    r_up    = DATA_W'($urandom);
    r_ack   = DATA_W'($urandom);
    write_config(r_first, r_up, r_ack, LEN_W'($urandom_range(int'(STORE_DEPTH), 8)));
    quiet_tail = 1'b1;
    run_random(35);
    wait_drained();

    if (mismatch_cnt == 0 && frame_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
